// ----- hdl/ffba_pkg.sv -----
// ffba_pkg: shared types and codes for the first-fit block allocator
// holds the table entry layout, status and mode codes, fixed field widths
// no dependencies
package ffba_pkg;

    localparam int FIELD_W     = 21;  // address and size fields
    localparam int SUM_W       = 22;  // request plus rounding slack
    localparam int NEWTOP_W    = 23;  // heap top plus aligned size plus header
    localparam int HANDLE_W    = 6;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;
    localparam logic [1:0] ST_BAD  = 2'd3;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    typedef struct packed {
        logic               used;
        logic [FIELD_W-1:0] base;
        logic [FIELD_W-1:0] size;
    } entry_t;

endpackage

// ----- hdl/first_fit_block_allocator.sv -----
// first_fit_block_allocator: first-fit heap block table with bump growth
// depends on ffba_pkg and ffba_ram (block table storage)
//
// channel   direction  handshake                 payload
// command   in         start, busy               mode, request_size, block_handle
// result    out        done (one-cycle strobe)   status, granted_handle,
//                                                payload_address, granted_size, reused
// config    in         cfg_valid, cfg_ready      cfg_data (heap_limit)
//
// allocate: the size is first rounded (reciprocal multiply, then scale back), then the
// scan reads one table entry per cycle from the single ram port until a free entry
// fits and is reused, or the heap grows once every entry has been checked
// free: ram read then write back; a bad handle reports without the sequencer leaving idle
// done pulses in the cycle that busy drops; the receiver cannot stall
// reset clears the count, heap top and control; table contents need no clearing
module first_fit_block_allocator
    import ffba_pkg::*;
#(
    parameter int MAX_BLOCKS   = 64,
    parameter int WORD_BYTES   = 8,
    parameter int HEADER_BYTES = 24,
    parameter int ADDR_BITS    = 20
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                mode,
    input  logic [FIELD_W-1:0]  request_size,
    input  logic [HANDLE_W-1:0] block_handle,
    output logic                done,
    output logic [1:0]          status,
    output logic [HANDLE_W-1:0] granted_handle,
    output logic [FIELD_W-1:0]  payload_address,
    output logic [FIELD_W-1:0]  granted_size,
    output logic                reused,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [FIELD_W-1:0]  cfg_data
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int CMP_W = (CNT_W > HANDLE_W) ? CNT_W : HANDLE_W;
    localparam logic [SUM_W-1:0] ADDR_CAP =
        (ADDR_BITS >= FIELD_W) ? (SUM_W'(1) << FIELD_W) : (SUM_W'(1) << ADDR_BITS);

    // word size is at most 8, so three extra fraction bits keep the quotient exact
    localparam int RECIP_SHIFT = SUM_W + 3;
    localparam int RECIP_W     = SUM_W + 2;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << RECIP_SHIFT) + longint'(WORD_BYTES) - longint'(1))
                 / longint'(WORD_BYTES));

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALIGN = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_GROW  = 3'd3;
    localparam logic [2:0] S_FREE  = 3'd4;
    localparam logic [2:0] S_ROUND = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [FIELD_W-1:0]  limit_reg, limit_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FIELD_W-1:0]  top_reg, top_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [QUOT_W-1:0]   quot_reg, quot_next;
    logic [SUM_W-1:0]    aligned_reg, aligned_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic                done_reg, done_next;
    logic [1:0]          status_reg, status_next;
    logic [HANDLE_W-1:0] ghandle_reg, ghandle_next;
    logic [FIELD_W-1:0]  paddr_reg, paddr_next;
    logic [FIELD_W-1:0]  gsize_reg, gsize_next;
    logic                reused_reg, reused_next;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_addr;
    entry_t              ram_wdata;
    entry_t              rd_entry;

    logic [PROD_W-1:0]   prod;
    logic [SUM_W-1:0]    limit_eff;
    logic [NEWTOP_W-1:0] new_top;
    logic                hit;
    logic                full;
    logic                oom;
    logic                handle_bad;

    ffba_ram #(
        .WIDTH($bits(entry_t)),
        .DEPTH(MAX_BLOCKS)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .addr (ram_addr),
        .wdata(ram_wdata),
        .rdata(rd_entry)
    );

    // padded request divided by the word size through its reciprocal
    assign prod       = PROD_W'(sum_reg) * PROD_W'(RECIP);

    assign limit_eff  = (SUM_W'(limit_reg) < ADDR_CAP) ? SUM_W'(limit_reg) : ADDR_CAP;
    assign new_top    = NEWTOP_W'(top_reg) + NEWTOP_W'(aligned_reg)
                      + NEWTOP_W'(HEADER_BYTES);
    assign oom        = new_top > NEWTOP_W'(limit_eff);
    assign full       = count_reg == CNT_W'(MAX_BLOCKS);
    assign hit        = pend_reg && !rd_entry.used
                      && (SUM_W'(rd_entry.size) >= aligned_reg);
    assign handle_bad = CMP_W'(block_handle) >= CMP_W'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        limit_next   = limit_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        sum_next     = sum_reg;
        quot_next    = quot_reg;
        aligned_next = aligned_reg;
        scan_next    = scan_reg;
        pend_next    = pend_reg;
        pidx_next    = pidx_reg;
        done_next    = 1'b0;
        status_next  = status_reg;
        ghandle_next = ghandle_reg;
        paddr_next   = paddr_reg;
        gsize_next   = gsize_reg;
        reused_next  = reused_reg;
        ram_we       = 1'b0;
        ram_addr     = scan_reg[IDX_W-1:0];
        ram_wdata    = '0;

        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (mode == MODE_FREE)
                    begin
                        if (handle_bad)
                        begin
                            done_next    = 1'b1;
                            status_next  = ST_BAD;
                            ghandle_next = block_handle;
                            paddr_next   = '0;
                            gsize_next   = '0;
                            reused_next  = 1'b0;
                        end
                        else
                        begin
                            ram_addr   = IDX_W'(block_handle);
                            pidx_next  = IDX_W'(block_handle);
                            state_next = S_FREE;
                        end
                    end
                    else
                    begin
                        sum_next   = SUM_W'(request_size) + SUM_W'(WORD_BYTES - 1);
                        state_next = S_ALIGN;
                    end
                end
            end

            S_ALIGN:
            begin
                quot_next  = prod[PROD_W-1:RECIP_SHIFT];
                state_next = S_ROUND;
            end

            S_ROUND:
            begin
                aligned_next = SUM_W'(quot_reg) * SUM_W'(WORD_BYTES);
                scan_next    = '0;
                pend_next    = 1'b0;
                state_next   = S_SCAN;
            end

            S_SCAN:
            begin
                // read of entry scan_reg overlaps the check of the entry before it
                if (hit)
                begin
                    ram_we         = 1'b1;
                    ram_addr       = pidx_reg;
                    ram_wdata      = rd_entry;
                    ram_wdata.used = 1'b1;
                    pend_next      = 1'b0;
                    done_next      = 1'b1;
                    status_next    = ST_OK;
                    ghandle_next   = HANDLE_W'(pidx_reg);
                    paddr_next     = rd_entry.base + FIELD_W'(HEADER_BYTES);
                    gsize_next     = rd_entry.size;
                    reused_next    = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (scan_reg < count_reg)
                begin
                    ram_addr  = scan_reg[IDX_W-1:0];
                    pidx_next = scan_reg[IDX_W-1:0];
                    pend_next = 1'b1;
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_GROW;
                end
            end

            S_GROW:
            begin
                done_next  = 1'b1;
                state_next = S_IDLE;
                if (full || oom)
                begin
                    status_next  = full ? ST_FULL : ST_OOM;
                    ghandle_next = '0;
                    paddr_next   = '0;
                    gsize_next   = '0;
                    reused_next  = 1'b0;
                end
                else
                begin
                    ram_we         = 1'b1;
                    ram_addr       = count_reg[IDX_W-1:0];
                    ram_wdata.used = 1'b1;
                    ram_wdata.base = top_reg;
                    ram_wdata.size = aligned_reg[FIELD_W-1:0];
                    count_next     = count_reg + CNT_W'(1);
                    top_next       = new_top[FIELD_W-1:0];
                    status_next    = ST_OK;
                    ghandle_next   = HANDLE_W'(count_reg);
                    paddr_next     = top_reg + FIELD_W'(HEADER_BYTES);
                    gsize_next     = aligned_reg[FIELD_W-1:0];
                    reused_next    = 1'b0;
                end
            end

            S_FREE:
            begin
                ram_we         = 1'b1;
                ram_addr       = pidx_reg;
                ram_wdata      = rd_entry;
                ram_wdata.used = 1'b0;
                done_next      = 1'b1;
                status_next    = ST_OK;
                ghandle_next   = HANDLE_W'(pidx_reg);
                paddr_next     = rd_entry.base + FIELD_W'(HEADER_BYTES);
                gsize_next     = rd_entry.size;
                reused_next    = 1'b0;
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= FIELD_W'(1048576);
            count_reg <= '0;
            top_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            limit_reg <= limit_next;
            count_reg <= count_next;
            top_reg   <= top_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg     <= sum_next;
        quot_reg    <= quot_next;
        aligned_reg <= aligned_next;
        scan_reg    <= scan_next;
        pidx_reg    <= pidx_next;
        status_reg  <= status_next;
        ghandle_reg <= ghandle_next;
        paddr_reg   <= paddr_next;
        gsize_reg   <= gsize_next;
        reused_reg  <= reused_next;
    end

    assign busy            = state_reg != S_IDLE;
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign status          = status_reg;
    assign granted_handle  = ghandle_reg;
    assign payload_address = paddr_reg;
    assign granted_size    = gsize_reg;
    assign reused          = reused_reg;

    // a result only appears once the sequencer is back at rest
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BLOCKS))
        else $error("block count beyond table size");

    assert property (@(posedge clk) disable iff (!rst_n)
        SUM_W'(top_reg) <= ADDR_CAP)
        else $error("heap top beyond address space");

    // a free of an unknown handle reports in the next cycle without touching state
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (mode == MODE_FREE) && handle_bad)
        |=> (done && (status == ST_BAD) && $stable(count_reg)))
        else $error("bad handle not reported");

endmodule

// ----- hdl/ffba_ram.sv -----
// ffba_ram: generic single-port ram with registered read
// one access per cycle, read returns the old contents on a write
// no dependencies
module ffba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
